// ----- hdl/cbsi_pkg.sv -----
// Shared types and constants for the cartridge bank switch with scanline IRQ.
package cbsi_pkg;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_VIDEO = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   typedef enum logic [0:0] {
      CSR_MIRRORING_RESET    = 1'b0,
      CSR_EDGE_FILTER_CYCLES = 1'b1
   } csr_index_type;

   localparam int CycleWidth = 48;
   localparam int FilterWidth = 4;
   localparam int CsrDataWidth = 4;

   localparam logic [15:0] WriteDecodeMask = 16'hF007;
   localparam logic [15:0] PrgBankLo       = 16'h8000;
   localparam logic [15:0] PrgBankHi       = 16'h8003;
   localparam logic [15:0] ChrBankLo       = 16'h9000;
   localparam logic [15:0] ChrBankHi       = 16'h9007;
   localparam logic [15:0] IrqDisableAddr  = 16'hC002;
   localparam logic [15:0] IrqEnableAddr   = 16'hC003;
   localparam logic [15:0] IrqLoadAddr     = 16'hC005;
   localparam logic [15:0] MirrorAddr      = 16'hD001;
   localparam logic [15:0] ChrSpaceEnd     = 16'h2000;
   localparam logic [15:0] PrgSpaceStart   = 16'h8000;

   localparam logic [7:0] PrgLastBank = 8'hFF;
   localparam logic [FilterWidth-1:0] FilterReset = 4'd3;

   typedef struct packed {
      logic [1:0]            operation;
      logic [15:0]           address;
      logic [7:0]            write_value;
      logic [CycleWidth-1:0] cpu_cycle;
   } item_type;

   typedef struct packed {
      logic       irq_line;
      logic       mirror_horizontal;
      logic [7:0] selected_bank;
   } result_type;

   typedef struct packed {
      logic irq_enable;
      logic irq_pending;
   } status_type;

endpackage

// ----- hdl/cbsi_if.sv -----
// Valid/ready channel interfaces for request and response words.
interface cbsi_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [15:0] address;
   logic [7:0]  write_value;
   logic [cbsi_pkg::CycleWidth-1:0] cpu_cycle;

   modport source (output valid, output operation, output address, output write_value,
                   output cpu_cycle, input ready);
   modport sink (input valid, input operation, input address, input write_value,
                 input cpu_cycle, output ready);
endinterface

interface cbsi_rsp_if;
   logic       valid;
   logic       ready;
   logic       irq_line;
   logic       mirror_horizontal;
   logic [7:0] selected_bank;

   modport source (output valid, output irq_line, output mirror_horizontal,
                   output selected_bank, input ready);
   modport sink (input valid, input irq_line, input mirror_horizontal,
                 input selected_bank, output ready);
endinterface

// ----- hdl/cbsi_core.sv -----
// Mapper state: bank registers, edge filter on address line 12, IRQ counter and result logic.
module cbsi_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  cbsi_pkg::item_type    item,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [cbsi_pkg::CsrDataWidth-1:0] csr_wdata,
   output cbsi_pkg::result_type  result,
   output cbsi_pkg::status_type  status
);

   logic [7:0] prg_ff [4];
   logic [7:0] prg_in [4];
   logic [7:0] chr_ff [8];
   logic [7:0] chr_in [8];
   logic [7:0] count_ff, count_in;
   logic       enable_ff, enable_in;
   logic       pending_ff, pending_in;
   logic       mirror_ff, mirror_in;
   logic       low_valid_ff, low_valid_in;
   logic [cbsi_pkg::CycleWidth-1:0] low_since_ff, low_since_in;
   logic [cbsi_pkg::FilterWidth-1:0] filter_ff, filter_in;

   logic [15:0] key;
   logic [cbsi_pkg::CycleWidth:0] diff;
   logic        rise;
   logic [7:0]  count_dec;
   logic [7:0]  bank;

   assign key = item.address & cbsi_pkg::WriteDecodeMask;
   assign diff = {1'b0, item.cpu_cycle} - {1'b0, low_since_ff};
   assign count_dec = count_ff - 8'd1;

   always_comb begin
      if (!low_valid_ff || !item.address[12]) begin
         rise = 1'b0;
      end else if (diff[cbsi_pkg::CycleWidth]) begin
         rise = (filter_ff == '0);
      end else begin
         rise = (diff[cbsi_pkg::CycleWidth-1:0] >=
                 {{(cbsi_pkg::CycleWidth-cbsi_pkg::FilterWidth){1'b0}}, filter_ff});
      end
   end

   always_comb begin
      prg_in       = prg_ff;
      chr_in       = chr_ff;
      count_in     = count_ff;
      enable_in    = enable_ff;
      pending_in   = pending_ff;
      mirror_in    = mirror_ff;
      low_valid_in = low_valid_ff;
      low_since_in = low_since_ff;
      filter_in    = filter_ff;
      bank         = 8'd0;
      case (cbsi_pkg::op_type'(item.operation))
         cbsi_pkg::OP_WRITE: begin
            if (key inside {[cbsi_pkg::PrgBankLo:cbsi_pkg::PrgBankHi]}) begin
               prg_in[key[1:0]] = item.write_value;
            end else if (key inside {[cbsi_pkg::ChrBankLo:cbsi_pkg::ChrBankHi]}) begin
               chr_in[key[2:0]] = item.write_value;
            end else if (key == cbsi_pkg::IrqDisableAddr) begin
               enable_in  = 1'b0;
               pending_in = 1'b0;
            end else if (key == cbsi_pkg::IrqEnableAddr) begin
               enable_in = 1'b1;
            end else if (key == cbsi_pkg::IrqLoadAddr) begin
               count_in = item.write_value;
            end else if (key == cbsi_pkg::MirrorAddr) begin
               mirror_in = item.write_value[0];
            end
         end
         cbsi_pkg::OP_VIDEO: begin
            if (item.address[12]) begin
               low_valid_in = 1'b0;
               low_since_in = '0;
            end else if (!low_valid_ff) begin
               low_valid_in = 1'b1;
               low_since_in = item.cpu_cycle;
            end
            if (rise && enable_ff) begin
               count_in = count_dec;
               if (count_dec == 8'd0) begin
                  enable_in  = 1'b0;
                  pending_in = 1'b1;
               end
            end
            if (item.address < cbsi_pkg::ChrSpaceEnd) begin
               bank = chr_ff[item.address[12:10]];
            end
         end
         cbsi_pkg::OP_READ: begin
            if (item.address >= cbsi_pkg::PrgSpaceStart) begin
               bank = prg_ff[item.address[14:13]];
            end
         end
         default: begin
         end
      endcase
      // csr writes should land only while idle; the block itself does not enforce this
      if (csr_we) begin
         case (cbsi_pkg::csr_index_type'(csr_index))
            cbsi_pkg::CSR_MIRRORING_RESET:    mirror_in = csr_wdata[0];
            cbsi_pkg::CSR_EDGE_FILTER_CYCLES: filter_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign result.irq_line          = pending_in;
   assign result.mirror_horizontal = mirror_in;
   assign result.selected_bank     = bank;
   assign status.irq_enable        = enable_ff;
   assign status.irq_pending       = pending_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_ff       <= '{8'd0, 8'd0, 8'd0, cbsi_pkg::PrgLastBank};
         chr_ff       <= '{default: 8'd0};
         count_ff     <= 8'd0;
         enable_ff    <= 1'b0;
         pending_ff   <= 1'b0;
         mirror_ff    <= 1'b0;
         low_valid_ff <= 1'b0;
         low_since_ff <= '0;
         filter_ff    <= cbsi_pkg::FilterReset;
      end else if (fire) begin
         prg_ff       <= prg_in;
         chr_ff       <= chr_in;
         count_ff     <= count_in;
         enable_ff    <= enable_in;
         pending_ff   <= pending_in;
         mirror_ff    <= mirror_in;
         low_valid_ff <= low_valid_in;
         low_since_ff <= low_since_in;
         filter_ff    <= filter_in;
      end else if (csr_we) begin
         mirror_ff <= mirror_in;
         filter_ff <= filter_in;
      end
   end

endmodule

// ----- hdl/cartridge_bank_switch_scanline_irq_top.sv -----
// Top level: input word register, mapper core and output word register.
//
//   port      dir   role
//   req_if    in    request words: operation, address, write_value, cpu_cycle
//   rsp_if    out   response words: irq_line, mirror_horizontal, selected_bank
//   csr_*     in    config writes: index 0 mirroring reset, 1 edge filter cycles
//
// One word per cycle sustained while rsp_if.ready holds; a request word passes
// the input register, then core logic into the output register.
// Synchronous active-high reset; banks, IRQ state and filter take reset values.
// A stalled response holds in the output register while the input register
// still takes one more word; req_if.ready drops only when both are full.
module cartridge_bank_switch_scanline_irq_top (
   input  logic              clock,
   input  logic              reset,
   cbsi_req_if.sink          req_if,
   cbsi_rsp_if.source        rsp_if,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [cbsi_pkg::CsrDataWidth-1:0] csr_wdata
);

   logic                 in_vld_ff, in_vld_in;
   cbsi_pkg::item_type   item_ff;
   logic                 out_vld_ff, out_vld_in;
   cbsi_pkg::result_type res_ff;
   cbsi_pkg::result_type core_res;
   cbsi_pkg::status_type core_status;
   logic                 fire;
   logic                 req_take;

   assign fire     = in_vld_ff && (!out_vld_ff || rsp_if.ready);
   assign req_take = req_if.valid && req_if.ready;
   assign req_if.ready = !in_vld_ff || fire;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_take) begin
         in_vld_in = 1'b1;
      end else if (fire) begin
         in_vld_in = 1'b0;
      end
      out_vld_in = out_vld_ff;
      if (fire) begin
         out_vld_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.operation   <= req_if.operation;
         item_ff.address     <= req_if.address;
         item_ff.write_value <= req_if.write_value;
         item_ff.cpu_cycle   <= req_if.cpu_cycle;
      end
      if (fire) begin
         res_ff <= core_res;
      end
   end

   cbsi_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .item      (item_ff),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .result    (core_res),
      .status    (core_status)
   );

   assign rsp_if.valid             = out_vld_ff;
   assign rsp_if.irq_line          = res_ff.irq_line;
   assign rsp_if.mirror_horizontal = res_ff.mirror_horizontal;
   assign rsp_if.selected_bank     = res_ff.selected_bank;

`ifndef SYNTH
   a_irq_from_enable: assert property (@(posedge clock) disable iff (reset)
      $rose(core_status.irq_pending) |-> $past(core_status.irq_enable))
      else $error("irq raised while counting disabled");

   a_rsp_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ready |=> rsp_if.valid)
      else $error("stalled response word withdrawn");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !rsp_if.ready |=> $stable(res_ff))
      else $error("stalled response word overwritten");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !fire |=> in_vld_ff)
      else $error("held request word dropped");
`endif

endmodule

// ----- tb/sv/cartridge_bank_switch_scanline_irq_top_test.sv -----
// Self-checking testbench for the cartridge bank switch with scanline IRQ.
module cartridge_bank_switch_scanline_irq_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import cbsi_pkg::*;

   localparam logic [1:0] OpUnused = 2'd3;
   localparam int unsigned DrainCycles = 4;
   localparam int unsigned WatchdogLimit = 3000;
   localparam int unsigned WordsPerPhase = 170;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic csr_index;
   logic [CsrDataWidth-1:0] csr_wdata;

   cbsi_req_if req_chan ();
   cbsi_rsp_if rsp_chan ();

   cartridge_bank_switch_scanline_irq_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_chan),
      .rsp_if    (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // mapper state as the block should hold it
   logic [7:0]            prg_banks [4];
   logic [7:0]            chr_banks [8];
   logic [7:0]            irq_count;
   logic                  irq_enable;
   logic                  irq_pending;
   logic                  mirror_state;
   logic [CycleWidth-1:0] low_since;
   logic                  low_valid;
   logic [FilterWidth-1:0] filter_cfg;

   item_type        pending_words [$];
   result_type      expected_responses [$];
   logic [CycleWidth-1:0] cpu_now;
   int unsigned     error_count = 0;
   int unsigned     idle_cycles = 0;
   int unsigned     req_gap = 0;
   int unsigned     req_calm = 0;
   int unsigned     rsp_stall = 0;
   int unsigned     rsp_calm = 0;

   function automatic result_type mapper_response(input item_type w);
      result_type r;
      logic [15:0] key;
      logic [CycleWidth-1:0] elapsed;
      logic rise;
      r.irq_line = 1'b0;
      r.mirror_horizontal = 1'b0;
      r.selected_bank = '0;
      rise = 1'b0;
      key = w.address & WriteDecodeMask;
      case (w.operation)
         OP_WRITE: begin
            if (key >= PrgBankLo && key <= PrgBankHi) begin
               prg_banks[key[1:0]] = w.write_value;
            end else if (key >= ChrBankLo && key <= ChrBankHi) begin
               chr_banks[key[2:0]] = w.write_value;
            end else if (key == IrqDisableAddr) begin
               irq_enable = 1'b0;
               irq_pending = 1'b0;
            end else if (key == IrqEnableAddr) begin
               irq_enable = 1'b1;
            end else if (key == IrqLoadAddr) begin
               irq_count = w.write_value;
            end else if (key == MirrorAddr) begin
               mirror_state = w.write_value[0];
            end
         end
         OP_VIDEO: begin
            if (w.address[12]) begin
               if (low_valid) begin
                  elapsed = (w.cpu_cycle >= low_since) ? w.cpu_cycle - low_since : '0;
                  rise = elapsed >= CycleWidth'(filter_cfg);
               end
               low_valid = 1'b0;
               low_since = '0;
            end else if (!low_valid) begin
               low_valid = 1'b1;
               low_since = w.cpu_cycle;
            end
            if (rise && irq_enable) begin
               irq_count = irq_count - 8'd1;
               if (irq_count == 8'd0) begin
                  irq_enable = 1'b0;
                  irq_pending = 1'b1;
               end
            end
            if (w.address < ChrSpaceEnd) r.selected_bank = chr_banks[w.address[12:10]];
         end
         OP_READ: begin
            if (w.address >= PrgSpaceStart) r.selected_bank = prg_banks[w.address[14:13]];
         end
         default: ;
      endcase
      r.irq_line = irq_pending;
      r.mirror_horizontal = mirror_state;
      return r;
   endfunction

   // mostly no pause, some short ones, a few long ones, and calm stretches
   function automatic int unsigned pick_pause(inout int unsigned calm);
      int unsigned r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) calm = $urandom_range(20, 80);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [15:0] alias_addr(input logic [15:0] key);
      return key | (16'($urandom) & ~WriteDecodeMask);
   endfunction

   function automatic logic [15:0] video_addr(input logic line12);
      logic [15:0] a;
      a = 16'($urandom);
      if ($urandom_range(0, 9) < 7) a[15:13] = 3'b000;
      a[12] = line12;
      return a;
   endfunction

   task automatic push_word(input logic [1:0] op, input logic [15:0] addr,
                            input logic [7:0] data, input int unsigned step);
      item_type w;
      w.operation = op;
      w.address = addr;
      w.write_value = data;
      w.cpu_cycle = cpu_now;
      pending_words.push_back(w);
      cpu_now = cpu_now + CycleWidth'(step);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [CsrDataWidth-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_MIRRORING_RESET) begin
         mirror_state = value[0];
      end else begin
         filter_cfg = value[FilterWidth-1:0];
      end
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_words.size() != 0 || req_chan.valid || expected_responses.size() != 0);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic add_random_words(input int unsigned count);
      int unsigned made;
      int unsigned kind;
      int unsigned edges;
      int unsigned lows;
      int unsigned k;
      int unsigned i;
      logic [2:0] slot;
      made = 0;
      while (made < count) begin
         kind = $urandom_range(0, 99);
         if (kind < 40) begin
            if ($urandom_range(0, 3) != 0) begin
               push_word(OP_WRITE, alias_addr(IrqLoadAddr),
                         ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5)), 1);
               push_word(OP_WRITE, alias_addr(IrqEnableAddr), 8'($urandom), 1);
               made += 2;
            end
            edges = $urandom_range(2, 10);
            for (k = 0; k < edges; k++) begin
               lows = $urandom_range(1, 3);
               for (i = 0; i < lows; i++) begin
                  push_word(OP_VIDEO, video_addr(1'b0), 8'($urandom),
                            $urandom_range(0, filter_cfg + 2));
               end
               push_word(OP_VIDEO, video_addr(1'b1), 8'($urandom), $urandom_range(0, 2));
               made += lows + 1;
            end
         end else if (kind < 65) begin
            slot = 3'($urandom);
            if ($urandom_range(0, 1) == 0) begin
               push_word(OP_WRITE, alias_addr(PrgBankLo | 16'(slot[1:0])), 8'($urandom), 1);
               push_word(OP_READ, {1'b1, slot[1:0], 13'($urandom)}, 8'($urandom), 1);
            end else begin
               push_word(OP_WRITE, alias_addr(ChrBankLo | 16'(slot)), 8'($urandom), 1);
               push_word(OP_VIDEO, {3'b000, slot, 10'($urandom)}, 8'($urandom), 1);
            end
            made += 2;
         end else if (kind < 78) begin
            if ($urandom_range(0, 1) == 0) begin
               push_word(OP_READ, 16'($urandom) | (($urandom_range(0, 3) != 0) ? PrgSpaceStart : 16'h0),
                         8'($urandom), $urandom_range(0, 2));
            end else begin
               push_word(OP_VIDEO, 16'($urandom), 8'($urandom), $urandom_range(0, 2));
            end
            made += 1;
         end else if (kind < 86) begin
            push_word(OP_WRITE,
                      alias_addr(($urandom_range(0, 1) == 0) ? IrqDisableAddr : IrqEnableAddr),
                      8'($urandom), 1);
            made += 1;
         end else if (kind < 95) begin
            push_word(2'($urandom_range(0, 3)), 16'($urandom), 8'($urandom), $urandom_range(0, 3));
            made += 1;
         end else if ($urandom_range(0, 1) == 0) begin
            // cycle count steps backwards
            if (cpu_now > 48'd32) cpu_now = cpu_now - CycleWidth'($urandom_range(1, 20));
            push_word(OP_VIDEO, video_addr(1'($urandom)), 8'($urandom), 0);
            made += 1;
         end else begin
            push_word(OP_WRITE, alias_addr(MirrorAddr), 8'($urandom), 1);
            made += 1;
         end
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            expected_responses.push_back(mapper_response(item_type'{req_chan.operation,
               req_chan.address, req_chan.write_value, req_chan.cpu_cycle}));
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_chan.valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               item_type w;
               w = pending_words.pop_front();
               req_chan.operation <= w.operation;
               req_chan.address <= w.address;
               req_chan.write_value <= w.write_value;
               req_chan.cpu_cycle <= w.cpu_cycle;
               req_chan.valid <= 1'b1;
               req_gap = pick_pause(req_calm);
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name, input int unsigned expv, input int unsigned actv);
      if (expv != actv) begin
         $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, expv, actv);
         error_count++;
      end
   endtask

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_responses.size() == 0) begin
               $display("%0t ns: unexpected response word, expected none actual %0h/%0h/%0h",
                        $time, rsp_chan.irq_line, rsp_chan.mirror_horizontal,
                        rsp_chan.selected_bank);
               error_count++;
            end else begin
               result_type e;
               e = expected_responses.pop_front();
               check_field("irq_line", 32'(e.irq_line), 32'(rsp_chan.irq_line));
               check_field("mirror_horizontal", 32'(e.mirror_horizontal),
                           32'(rsp_chan.mirror_horizontal));
               check_field("selected_bank", 32'(e.selected_bank), 32'(rsp_chan.selected_bank));
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            rsp_stall = pick_pause(rsp_calm);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WatchdogLimit) begin
            $display("%0t ns: no handshake for %0d cycles", $time, idle_cycles);
            $display("cartridge_bank_switch_scanline_irq_top_test failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      int unsigned p;
      logic [FilterWidth-1:0] filter_plan [4];
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_MIRRORING_RESET;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.operation = OP_WRITE;
      req_chan.address = '0;
      req_chan.write_value = '0;
      req_chan.cpu_cycle = '0;
      rsp_chan.ready = 1'b0;
      for (int s = 0; s < 4; s++) prg_banks[s] = '0;
      prg_banks[3] = PrgLastBank;
      for (int s = 0; s < 8; s++) chr_banks[s] = '0;
      irq_count = '0;
      irq_enable = 1'b0;
      irq_pending = 1'b0;
      mirror_state = 1'b0;
      low_since = '0;
      low_valid = 1'b0;
      filter_cfg = FilterReset;
      filter_plan = '{4'd15, 4'd1, 4'd0, 4'd7};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed pass at reset settings
      cpu_now = '0;
      push_word(OP_READ, 16'hE000, 8'h00, 1);
      push_word(OP_READ, 16'h7FFF, 8'h00, 1);
      push_word(OP_WRITE, 16'h8FF1, 8'hFF, 1);
      push_word(OP_READ, 16'hBFFF, 8'h00, 1);
      push_word(OP_WRITE, ChrBankHi, 8'hA5, 1);
      push_word(OP_WRITE, IrqLoadAddr, 8'h00, 1);
      push_word(OP_WRITE, IrqEnableAddr, 8'h00, 1);
      push_word(OP_VIDEO, 16'h0C00, 8'h00, 3);
      push_word(OP_VIDEO, 16'h1FFF, 8'h00, 0);   // counter loaded with zero wraps
      push_word(OP_WRITE, IrqLoadAddr, 8'h01, 1);
      push_word(OP_VIDEO, 16'h0000, 8'h00, 2);
      push_word(OP_VIDEO, 16'h1000, 8'h00, 1);   // too short, filtered out
      push_word(OP_VIDEO, 16'h2000, 8'h00, 3);   // outside character space
      push_word(OP_VIDEO, 16'h3000, 8'h00, 1);   // counts to zero, raises IRQ
      push_word(OP_WRITE, MirrorAddr, 8'h01, 1);
      push_word(OP_WRITE, IrqDisableAddr, 8'h00, 1);
      push_word(OP_WRITE, MirrorAddr, 8'hFE, 1);
      push_word(OP_WRITE, IrqLoadAddr, 8'h02, 0);
      push_word(OP_WRITE, IrqEnableAddr, 8'h00, 0);
      cpu_now = 48'hFFFF_FFFF_FFFF;
      push_word(OP_VIDEO, 16'h0400, 8'h00, 0);
      cpu_now = 48'h0000_0000_0010;
      push_word(OP_VIDEO, 16'h1400, 8'h00, 0);   // cycle count went backwards
      push_word(OpUnused, 16'hFFFF, 8'hFF, 0);
      push_word(OP_READ, 16'hFFFF, 8'h00, 0);
      push_word(OP_WRITE, 16'hFFFF, 8'h00, 0);
      wait_drained();

      for (p = 0; p < 5; p++) begin
         csr_write(CSR_MIRRORING_RESET, (p == 4) ? CsrDataWidth'($urandom_range(0, 1))
                                                 : CsrDataWidth'(p % 2 == 0));
         csr_write(CSR_EDGE_FILTER_CYCLES, (p == 4) ? CsrDataWidth'($urandom_range(0, 15))
                                                    : filter_plan[p]);
         cpu_now = {16'($urandom), 32'($urandom)} & 48'hFFFF_FFFF_C000;
         add_random_words(WordsPerPhase);
         wait_drained();
      end

      if (error_count == 0) begin
         $display("cartridge_bank_switch_scanline_irq_top_test passed");
      end else begin
         $display("cartridge_bank_switch_scanline_irq_top_test failed");
      end
      $finish;
   end

endmodule

// ----- cartridge_bank_switch_scanline_irq_top.f -----
hdl/cbsi_pkg.sv
hdl/cbsi_if.sv
hdl/cbsi_core.sv
hdl/cartridge_bank_switch_scanline_irq_top.sv
tb/sv/cartridge_bank_switch_scanline_irq_top_test.sv
